[rtl/vfrt_pkg.sv]
// Shared types, constants and status codes for the video fragment reassembly tracker.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package vfrt_pkg;

	// Largest fragment count that the received mask can track.
	localparam int unsigned MAX_FRAGMENTS = 8;
	localparam int unsigned IDX_W         = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int unsigned CNT_W         = $clog2(MAX_FRAGMENTS + 1);
	localparam int unsigned OFFSET_W      = IDX_W + 16;

	localparam logic [15:0] HEADER_BYTES = 16'd14;

	// Status codes of a result.
	localparam logic [2:0] ST_BAD_TYPE     = 3'd0;
	localparam logic [2:0] ST_BAD_LENGTH   = 3'd1;
	localparam logic [2:0] ST_BAD_FRAME_ID = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE     = 3'd3;
	localparam logic [2:0] ST_DUPLICATE    = 3'd4;
	localparam logic [2:0] ST_INCOMPLETE   = 3'd5;
	localparam logic [2:0] ST_OBSOLETE     = 3'd6;
	localparam logic [2:0] ST_READY        = 3'd7;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 23;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TYPE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_FRAME_BYTES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES          = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAGMENTS_PER_FRAME  = 3'd4;

	// Register reset values.
	localparam logic [7:0]  RST_EXPECTED_TYPE        = 8'd20;
	localparam logic [7:0]  RST_EXPECTED_VERSION     = 8'd1;
	localparam logic [22:0] RST_EXPECTED_FRAME_BYTES = 23'd261120;
	localparam logic [15:0] RST_CHUNK_BYTES          = 16'd59986;
	localparam logic [3:0]  RST_FRAGMENTS_PER_FRAME  = 4'd5;

	typedef struct packed {
		logic [15:0] packet_length;
		logic [7:0]  packet_type;
		logic [7:0]  packet_version;
		logic [15:0] frame_number;
		logic [15:0] fragment_index;
		logic [15:0] fragment_total;
		logic [31:0] frame_bytes;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        store_valid;
		logic [21:0] store_offset;
		logic [15:0] store_length;
		logic        display_select;
		logic [15:0] shown_frame_number;
	} result_t;

	typedef struct packed {
		logic [7:0]  expected_type;
		logic [7:0]  expected_version;
		logic [22:0] expected_frame_bytes;
		logic [15:0] chunk_bytes;
		logic [3:0]  fragments_per_frame;
	} cfg_t;

	typedef struct packed {
		logic                     active;
		logic [15:0]              frame_number;
		logic [3:0]               fragment_total;
		logic [MAX_FRAGMENTS-1:0] rx_mask;
		logic [CNT_W-1:0]         received_count;
		logic                     front_select;
		logic [15:0]              last_shown;
	} trk_state_t;

endpackage

`default_nettype wire

[rtl/vfrt_cfg.sv]
// Configuration register file of the reassembly tracker.
// Depends on vfrt_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module vfrt_cfg
	import vfrt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [CFG_INDEX_W-1:0] wr_index,
	input  wire logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_type        <= RST_EXPECTED_TYPE;
			cfg_q.expected_version     <= RST_EXPECTED_VERSION;
			cfg_q.expected_frame_bytes <= RST_EXPECTED_FRAME_BYTES;
			cfg_q.chunk_bytes          <= RST_CHUNK_BYTES;
			cfg_q.fragments_per_frame  <= RST_FRAGMENTS_PER_FRAME;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXPECTED_TYPE:        cfg_q.expected_type        <= wr_data[7:0];
				REG_EXPECTED_VERSION:     cfg_q.expected_version     <= wr_data[7:0];
				REG_EXPECTED_FRAME_BYTES: cfg_q.expected_frame_bytes <= wr_data[22:0];
				REG_CHUNK_BYTES:          cfg_q.chunk_bytes          <= wr_data[15:0];
				REG_FRAGMENTS_PER_FRAME:  cfg_q.fragments_per_frame  <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/vfrt_check.sv]
// Header checks and assembly decision for one packet, purely combinational.
// Depends on vfrt_pkg for item_t, cfg_t, trk_state_t, result_t and the status codes.
`timescale 1ns / 1ps
`default_nettype none

module vfrt_check
	import vfrt_pkg::*;
(
	input  wire item_t      item,
	input  wire cfg_t       cfg,
	input  wire trk_state_t cur,
	output trk_state_t      nxt,
	output result_t         result
);

	logic [15:0]         payload_len;
	logic [IDX_W-1:0]    idx_lo;
	logic [OFFSET_W-1:0] offset;
	logic [22:0]         remaining;
	logic [15:0]         clip_len;
	logic [CNT_W-1:0]    count_inc;
	logic                start;
	logic                go;
	logic [2:0]          status;
	logic                store_valid;

	assign payload_len = item.packet_length - HEADER_BYTES;
	assign idx_lo      = item.fragment_index[IDX_W-1:0];
	// The index is below MAX_FRAGMENTS whenever a store goes out, so the product is narrow.
	assign offset      = OFFSET_W'(idx_lo) * OFFSET_W'(cfg.chunk_bytes);
	assign remaining   = cfg.expected_frame_bytes - 23'(offset);
	assign clip_len    = (remaining < 23'(payload_len)) ? remaining[15:0] : payload_len;

	always_comb begin
		nxt         = cur;
		status      = ST_BAD_LENGTH;
		store_valid = 1'b0;
		start       = 1'b0;
		go          = 1'b0;
		count_inc   = cur.received_count;
		if (item.packet_length < HEADER_BYTES) begin
			status = ST_BAD_LENGTH;
		end else if (item.packet_type != cfg.expected_type
				|| item.packet_version != cfg.expected_version) begin
			status = ST_BAD_TYPE;
		end else if (item.frame_bytes != 32'(cfg.expected_frame_bytes)) begin
			status = ST_BAD_SIZE;
		end else if (item.fragment_total == 16'd0
				|| item.fragment_index >= item.fragment_total) begin
			status = ST_BAD_LENGTH;
		end else if (payload_len > cfg.chunk_bytes) begin
			status = ST_BAD_LENGTH;
		end else begin
			go = 1'b1;
			if (!cur.active) begin
				start = 1'b1;
			end else if (item.frame_number != cur.frame_number) begin
				if (item.frame_number < cur.frame_number) begin
					status = ST_OBSOLETE;
					go     = 1'b0;
				end else begin
					// A newer frame abandons the one in progress even if it fails to start.
					nxt.active         = 1'b0;
					nxt.frame_number   = '0;
					nxt.fragment_total = '0;
					nxt.rx_mask        = '0;
					nxt.received_count = '0;
					start              = 1'b1;
				end
			end else if (item.fragment_total != 16'(cur.fragment_total)) begin
				status = ST_BAD_LENGTH;
				go     = 1'b0;
			end

			if (start) begin
				if (item.frame_number == 16'd0) begin
					status = ST_BAD_FRAME_ID;
					go     = 1'b0;
				end else if (item.fragment_total != 16'(cfg.fragments_per_frame)) begin
					status = ST_BAD_LENGTH;
					go     = 1'b0;
				end else begin
					nxt.active         = 1'b1;
					nxt.frame_number   = item.frame_number;
					nxt.fragment_total = cfg.fragments_per_frame;
					nxt.rx_mask        = '0;
					nxt.received_count = '0;
				end
			end

			if (go) begin
				if (item.fragment_index >= 16'(cfg.fragments_per_frame)
						|| item.fragment_index >= 16'(MAX_FRAGMENTS)) begin
					status = ST_DUPLICATE;
				end else if (nxt.rx_mask[idx_lo]) begin
					status = ST_DUPLICATE;
				end else if (23'(offset) >= cfg.expected_frame_bytes) begin
					status = ST_DUPLICATE;
				end else if (clip_len == 16'd0) begin
					status = ST_DUPLICATE;
				end else begin
					store_valid                = 1'b1;
					count_inc                  = nxt.received_count + CNT_W'(1);
					nxt.rx_mask[idx_lo]        = 1'b1;
					nxt.received_count         = count_inc;
					if (16'(count_inc) == 16'(nxt.fragment_total)) begin
						status             = ST_READY;
						nxt.last_shown     = nxt.frame_number;
						nxt.front_select   = ~nxt.front_select;
						nxt.active         = 1'b0;
						nxt.frame_number   = '0;
						nxt.fragment_total = '0;
						nxt.rx_mask        = '0;
						nxt.received_count = '0;
					end else begin
						status = ST_INCOMPLETE;
					end
				end
			end
		end
	end

	always_comb begin
		result                    = '0;
		result.status             = status;
		result.store_valid        = store_valid;
		result.store_offset       = store_valid ? 22'(offset) : 22'd0;
		result.store_length       = store_valid ? clip_len : 16'd0;
		result.display_select     = nxt.front_select;
		result.shown_frame_number = nxt.last_shown;
	end

endmodule

`default_nettype wire

[rtl/video_fragment_reassembly_tracker.sv]
// Top level of the video fragment reassembly tracker: input register, tracking state,
// result register. Depends on vfrt_pkg, vfrt_cfg and vfrt_check.
//
// Usage. Each request on the item channel (item_valid / item_ready / item) carries the
// decoded header of one raw-video packet and its total length. For every request exactly
// one result leaves on the result channel (result_valid / result_ready / result): a status
// code, an optional store command (offset and length into the assembly buffer) and the
// display buffer select and shown frame id as they stand after that packet.
// A request taken into the input register has its decision made there; its result is
// written to the result register when the input stage advances and is offered from there.
// Throughput is one request per cycle while results are taken; the whole decision is one
// pass of the check logic between the two registers, and the tracking state is updated at
// the same edge as the result register, so the next packet sees it at once.
// When the receiver stalls, the result register holds its result and the input register
// still takes one more request; item_ready falls only when both are full.
// The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready
// and writes one register per request; indexes beyond the register list are ignored.
// Registers should be written only while no packet is in flight.
// Reset, asynchronous and active low, empties both registers, returns the configuration
// to its defaults, abandons any frame in progress and selects buffer A with shown id zero.
`timescale 1ns / 1ps
`default_nettype none

module video_fragment_reassembly_tracker
	import vfrt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire item_t                  item,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output result_t                     result,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t       cfg;
	item_t      item_s1;
	logic       valid_s1;
	result_t    result_s2;
	logic       valid_s2;
	trk_state_t trk_q;
	trk_state_t trk_nxt;
	result_t    check_result;
	logic       advance;

	// Configuration writes never stall.
	assign cfg_ready = 1'b1;

	vfrt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The input stage moves on when the result register is empty or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	vfrt_check u_check (
		.item   (item_s1),
		.cfg    (cfg),
		.cur    (trk_q),
		.nxt    (trk_nxt),
		.result (check_result)
	);

	// Tracking state: changes only when a packet's result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '0;
		end else if (advance) begin
			trk_q <= trk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= check_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

`default_nettype wire

[rtl/vfrt_checker.sv]
// Port-level checker for the reassembly tracker, bound to the top level.
// Depends on vfrt_pkg for the payload types and status codes.
`timescale 1ns / 1ps
`default_nettype none

module vfrt_checker
	import vfrt_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_ready,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// A stalled result stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Back-pressure reaches the item side only when the result side is full and stalled.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("item channel stalled without a stalled result");

	// A store command goes out only with an accepting status and a non-empty length.
	a_store_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.store_valid |->
			(result.status == ST_INCOMPLETE || result.status == ST_READY)
			&& result.store_length != 16'd0)
		else $error("store command with a rejecting status");

	// A frame completes only through a stored fragment; otherwise the store fields are zero.
	a_ready_store: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.store_valid |->
			result.status != ST_READY && result.status != ST_INCOMPLETE
			&& result.store_offset == 22'd0 && result.store_length == 16'd0)
		else $error("rejected packet carries store fields");

endmodule

bind video_fragment_reassembly_tracker vfrt_checker u_vfrt_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for video_fragment_reassembly_tracker: directed packets, register
// changes between phases and long runs of random fragment traffic under random back-pressure.
// Depends on vfrt_pkg and the tracker RTL only.
`timescale 1ns / 1ps

module testbench;
	import vfrt_pkg::*;

	// Far above the slowest correct run: about 1230 requests, each delayed at most by a sender
	// gap, a receiver stall and its pass through both registers, plus the drains.
	localparam int unsigned CYCLE_LIMIT   = 400000;
	// Cycles allowed after the last result before the block counts as idle.
	localparam int unsigned SETTLE_CYCLES = 4;
	// The store offset is 22 bits wide; offsets at or past this are never stored.
	localparam int unsigned OFFSET_SPAN   = 4194304;
	// Payload of a full fragment under the reset configuration.
	localparam int unsigned FULL_CHUNK    = 59986;
	localparam int unsigned PHASE_ITEMS   = 150;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_FRAGMENTS_PER_FRAME + 1'b1;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	item_t                  item         = '0;
	logic                   result_ready = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   item_ready;
	logic                   result_valid;
	result_t                result;
	logic                   cfg_ready;

	video_fragment_reassembly_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the configuration registers, updated on every accepted write.
	cfg_t shadow_cfg = '{RST_EXPECTED_TYPE, RST_EXPECTED_VERSION, RST_EXPECTED_FRAME_BYTES,
		RST_CHUNK_BYTES, RST_FRAGMENTS_PER_FRAME};

	// Shadow copy of the frame tracking state.
	bit                       asm_active   = 1'b0;
	logic [15:0]              asm_frame    = '0;
	logic [15:0]              asm_total    = '0;
	logic [MAX_FRAGMENTS-1:0] asm_mask     = '0;
	int unsigned              asm_count    = 0;
	logic                     shown_select = 1'b0;
	logic [15:0]              shown_frame  = '0;

	// Results still owed by the block, oldest first.
	result_t     owed_results[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Idling control: chance in percent of starting a burst, zero for a steady stream.
	int unsigned sender_gap_pct     = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned stall_left         = 0;

	// Frame id the random traffic is currently building.
	logic [15:0] stim_frame = 16'd1;

	function automatic void drop_assembly();
		asm_active = 1'b0;
		asm_frame  = '0;
		asm_total  = '0;
		asm_mask   = '0;
		asm_count  = 0;
	endfunction

	// Works out status and store command for one packet and advances the shadow state.
	// The display select and shown frame id are filled in by the caller from the state.
	function automatic result_t track_packet(input item_t p);
		result_t     r;
		int unsigned payload_len;
		int unsigned offset;
		int unsigned limit;
		int unsigned clip_len;
		r = '0;
		if (p.packet_length < HEADER_BYTES) begin
			r.status = ST_BAD_LENGTH;
			return r;
		end
		if (p.packet_type != shadow_cfg.expected_type ||
				p.packet_version != shadow_cfg.expected_version) begin
			r.status = ST_BAD_TYPE;
			return r;
		end
		if (p.frame_bytes != {9'd0, shadow_cfg.expected_frame_bytes}) begin
			r.status = ST_BAD_SIZE;
			return r;
		end
		if (p.fragment_total == '0 || p.fragment_index >= p.fragment_total) begin
			r.status = ST_BAD_LENGTH;
			return r;
		end
		payload_len = 32'(p.packet_length - HEADER_BYTES);
		if (payload_len > shadow_cfg.chunk_bytes) begin
			r.status = ST_BAD_LENGTH;
			return r;
		end
		if (!asm_active || p.frame_number != asm_frame) begin
			// An older id is dropped; a newer one abandons the frame in progress
			// before its own start checks, so even a failing packet clears it.
			if (asm_active && p.frame_number < asm_frame) begin
				r.status = ST_OBSOLETE;
				return r;
			end
			drop_assembly();
			if (p.frame_number == '0) begin
				r.status = ST_BAD_FRAME_ID;
				return r;
			end
			if (p.fragment_total != 16'(shadow_cfg.fragments_per_frame)) begin
				r.status = ST_BAD_LENGTH;
				return r;
			end
			asm_active = 1'b1;
			asm_frame  = p.frame_number;
			asm_total  = p.fragment_total;
		end else if (p.fragment_total != asm_total) begin
			r.status = ST_BAD_LENGTH;
			return r;
		end
		if (p.fragment_index >= 16'(shadow_cfg.fragments_per_frame) ||
				p.fragment_index >= 16'(MAX_FRAGMENTS)) begin
			r.status = ST_DUPLICATE;
			return r;
		end
		if (asm_mask[p.fragment_index[IDX_W-1:0]]) begin
			r.status = ST_DUPLICATE;
			return r;
		end
		offset = 32'(p.fragment_index);
		offset = offset * 32'(shadow_cfg.chunk_bytes);
		limit  = (32'(shadow_cfg.expected_frame_bytes) < OFFSET_SPAN) ?
			32'(shadow_cfg.expected_frame_bytes) : OFFSET_SPAN;
		if (offset >= limit) begin
			r.status = ST_DUPLICATE;
			return r;
		end
		// Clip the payload to the end of the frame as the frame size stands now.
		clip_len = 32'(shadow_cfg.expected_frame_bytes) - offset;
		if (payload_len < clip_len)
			clip_len = payload_len;
		if (clip_len == 0) begin
			r.status = ST_DUPLICATE;
			return r;
		end
		r.store_valid  = 1'b1;
		r.store_offset = offset[21:0];
		r.store_length = clip_len[15:0];
		asm_mask[p.fragment_index[IDX_W-1:0]] = 1'b1;
		asm_count++;
		if (asm_count == 32'(asm_total)) begin
			shown_frame  = asm_frame;
			shown_select = ~shown_select;
			drop_assembly();
			r.status = ST_READY;
		end else begin
			r.status = ST_INCOMPLETE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// One process samples every handshake just before the edge takes effect: register
	// writes update the shadow configuration, accepted requests queue their expected
	// result, and accepted results are compared with the oldest one waiting.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EXPECTED_TYPE:        shadow_cfg.expected_type        = cfg_data[7:0];
					REG_EXPECTED_VERSION:     shadow_cfg.expected_version     = cfg_data[7:0];
					REG_EXPECTED_FRAME_BYTES: shadow_cfg.expected_frame_bytes = cfg_data[22:0];
					REG_CHUNK_BYTES:          shadow_cfg.chunk_bytes          = cfg_data[15:0];
					REG_FRAGMENTS_PER_FRAME:  shadow_cfg.fragments_per_frame  = cfg_data[3:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				want = track_packet(item);
				want.display_select     = shown_select;
				want.shown_frame_number = shown_frame;
				owed_results.push_back(want);
			end
			if (result_valid && result_ready) begin
				if (owed_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with no request outstanding, status %0d", $time,
						result.status);
				end else begin
					want = owed_results.pop_front();
					if (result.status !== want.status)
						report_mismatch("status", want.status, result.status);
					if (result.store_valid !== want.store_valid)
						report_mismatch("store_valid", want.store_valid, result.store_valid);
					if (result.store_offset !== want.store_offset)
						report_mismatch("store_offset", want.store_offset, result.store_offset);
					if (result.store_length !== want.store_length)
						report_mismatch("store_length", want.store_length, result.store_length);
					if (result.display_select !== want.display_select)
						report_mismatch("display_select", want.display_select,
							result.display_select);
					if (result.shown_frame_number !== want.shown_frame_number)
						report_mismatch("shown_frame_number", want.shown_frame_number,
							result.shown_frame_number);
				end
			end
		end
	end

	// The receiver stalls in bursts of random length when a stall percentage is set.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct) begin
			stall_left = $urandom_range(0, 5);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** video_fragment_reassembly_tracker: FAILED **");
			$finish;
		end
	end

	// Sends one request, possibly after a burst of idle cycles, and returns at the edge
	// that accepts it. Valid stays high so that a following request goes out back to back.
	task automatic send_packet(input item_t p);
		if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= p;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every owed result has arrived and the block has settled.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it once its last write is taken.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		drain_results();
		write_register(REG_EXPECTED_TYPE, CFG_DATA_W'(s.expected_type));
		write_register(REG_EXPECTED_VERSION, CFG_DATA_W'(s.expected_version));
		write_register(REG_EXPECTED_FRAME_BYTES, CFG_DATA_W'(s.expected_frame_bytes));
		write_register(REG_CHUNK_BYTES, CFG_DATA_W'(s.chunk_bytes));
		write_register(REG_FRAGMENTS_PER_FRAME, CFG_DATA_W'(s.fragments_per_frame));
		cfg_valid <= 1'b0;
		// Let the shadow registers settle before packets are built.
		@(posedge clk);
	endtask

	function automatic cfg_t make_setting(input logic [7:0] ptype, input logic [7:0] version,
			input logic [22:0] size_bytes, input logic [15:0] chunk, input logic [3:0] frags);
		cfg_t s;
		s.expected_type        = ptype;
		s.expected_version     = version;
		s.expected_frame_bytes = size_bytes;
		s.chunk_bytes          = chunk;
		s.fragments_per_frame  = frags;
		return s;
	endfunction

	function automatic cfg_t random_setting();
		int unsigned frags;
		int unsigned chunk;
		int unsigned size_bytes;
		frags = $urandom_range(1, MAX_FRAGMENTS);
		chunk = $urandom_range(1, 65521);
		// Mostly a frame size that the fragments can actually cover.
		if ($urandom_range(0, 3) != 0)
			size_bytes = $urandom_range(1, frags * chunk);
		else
			size_bytes = $urandom_range(1, OFFSET_SPAN);
		return make_setting(8'($urandom), 8'($urandom), 23'(size_bytes), 16'(chunk),
			4'(frags));
	endfunction

	// A well-formed fragment header under the configuration as it stands.
	function automatic item_t fragment_header(input logic [15:0] id, input int unsigned index,
			input int unsigned payload_len);
		item_t p;
		p.packet_length  = 16'(32'(HEADER_BYTES) + payload_len);
		p.packet_type    = shadow_cfg.expected_type;
		p.packet_version = shadow_cfg.expected_version;
		p.frame_number   = id;
		p.fragment_index = 16'(index);
		p.fragment_total = 16'(shadow_cfg.fragments_per_frame);
		p.frame_bytes    = 32'(shadow_cfg.expected_frame_bytes);
		return p;
	endfunction

	// Mostly fragments of the frame being built, with random index and payload, so that
	// frames complete; the rest are newer and older ids, single corrupted fields and random headers.
	function automatic item_t random_packet();
		item_t       p;
		int unsigned pick;
		int unsigned payload_len;
		if (!asm_active && $urandom_range(0, 1) == 1)
			stim_frame = (stim_frame == 16'hFFFF) ? 16'd1 : stim_frame + 16'd1;
		if ($urandom_range(0, 9) < 6)
			payload_len = shadow_cfg.chunk_bytes;
		else
			payload_len = $urandom_range(0, shadow_cfg.chunk_bytes);
		p = fragment_header(stim_frame,
			$urandom_range(0, shadow_cfg.fragments_per_frame - 1), payload_len);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
		end else if (pick < 75) begin
			if (stim_frame < 16'hFFF0)
				stim_frame = stim_frame + 16'($urandom_range(1, 3));
			p.frame_number = stim_frame;
		end else if (pick < 80) begin
			p.frame_number = stim_frame - 16'd1;
		end else if (pick < 85) begin
			p.fragment_total = 16'($urandom_range(0, 15));
		end else if (pick < 88) begin
			p.fragment_index = 16'($urandom);
		end else if (pick < 91) begin
			p.packet_length = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 15)) :
				16'($urandom);
		end else if (pick < 93) begin
			p.packet_type = 8'($urandom);
		end else if (pick < 95) begin
			p.packet_version = 8'($urandom);
		end else if (pick < 97) begin
			p.frame_bytes = $urandom;
		end else begin
			p.packet_length  = 16'($urandom);
			p.packet_type    = 8'($urandom);
			p.packet_version = 8'($urandom);
			p.frame_number   = 16'($urandom);
			p.fragment_index = 16'($urandom);
			p.fragment_total = 16'($urandom);
			p.frame_bytes    = $urandom;
		end
		return p;
	endfunction

	// Every check and outcome once under the reset configuration, with the all-zero
	// and all-one headers as field extremes. The frame left open here is finished by
	// the mid-frame register test.
	task automatic test_directed_checks();
		item_t p;
		sender_gap_pct     = 20;
		receiver_stall_pct = 20;
		p = '0;
		send_packet(p);
		p = '1;
		send_packet(p);
		p = fragment_header(16'd1, 0, FULL_CHUNK);
		p.packet_length = HEADER_BYTES - 1'b1;
		send_packet(p);
		p = fragment_header(16'd1, 0, FULL_CHUNK);
		p.packet_type = p.packet_type ^ 8'h01;
		send_packet(p);
		p = fragment_header(16'd1, 0, FULL_CHUNK);
		p.packet_version = '0;
		send_packet(p);
		p = fragment_header(16'd1, 0, FULL_CHUNK);
		p.frame_bytes = p.frame_bytes + 1'b1;
		send_packet(p);
		p = fragment_header(16'd1, 0, FULL_CHUNK);
		p.fragment_total = '0;
		send_packet(p);
		// Index equal to the declared total, then a payload one byte too long.
		send_packet(fragment_header(16'd1, RST_FRAGMENTS_PER_FRAME, FULL_CHUNK));
		send_packet(fragment_header(16'd1, 0, FULL_CHUNK + 1));
		send_packet(fragment_header(16'd0, 0, FULL_CHUNK));
		p = fragment_header(16'd10, 0, FULL_CHUNK);
		p.fragment_total = 16'(RST_FRAGMENTS_PER_FRAME - 1'b1);
		send_packet(p);
		// Frame 10 starts, then a repeat, a count mismatch, an older id and an empty payload.
		send_packet(fragment_header(16'd10, 0, FULL_CHUNK));
		send_packet(fragment_header(16'd10, 0, FULL_CHUNK));
		p = fragment_header(16'd10, 1, FULL_CHUNK);
		p.fragment_total = 16'(RST_FRAGMENTS_PER_FRAME + 1'b1);
		send_packet(p);
		send_packet(fragment_header(16'd9, 1, FULL_CHUNK));
		send_packet(fragment_header(16'd10, 2, 0));
		// A newer id restarts; a failing newer id still throws the frame away.
		send_packet(fragment_header(16'd12, 1, FULL_CHUNK));
		p = fragment_header(16'd13, 0, FULL_CHUNK);
		p.fragment_total = 16'd3;
		send_packet(p);
		// Frame 12 from scratch to completion; the last fragment is clipped.
		for (int i = 0; i < RST_FRAGMENTS_PER_FRAME; i++)
			send_packet(fragment_header(16'd12, i, FULL_CHUNK));
		send_packet(fragment_header(16'hFFFF, 4, FULL_CHUNK));
		send_packet(fragment_header(16'hFFFE, 0, FULL_CHUNK));
		// The sender waits here until every result is back before going on.
		drain_results();
	endtask

	// Register writes to indexes past the list must change nothing.
	task automatic test_unused_register_indexes();
		drain_results();
		for (int i = REG_UNUSED_FIRST; i < (1 << CFG_INDEX_W); i++)
			write_register(CFG_INDEX_W'(i), '1);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Shrinking the frame size in the middle of a frame changes the clipping of the
	// fragments that follow; here the last fragment is cut short and still completes it.
	task automatic test_midframe_config_change();
		for (int i = 0; i < 3; i++)
			send_packet(fragment_header(16'hFFFF, i, FULL_CHUNK));
		drain_results();
		write_register(REG_EXPECTED_FRAME_BYTES, CFG_DATA_W'(3 * FULL_CHUNK + 500));
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_packet(fragment_header(16'hFFFF, 3, FULL_CHUNK));
		apply_settings(make_setting(RST_EXPECTED_TYPE, RST_EXPECTED_VERSION,
			RST_EXPECTED_FRAME_BYTES, RST_CHUNK_BYTES, RST_FRAGMENTS_PER_FRAME));
	endtask

	task automatic run_random_phase(input cfg_t s, input logic [15:0] first_frame,
			input bit steady, input bit pause_midway);
		apply_settings(s);
		if (asm_active)
			stim_frame = (asm_frame == 16'hFFFF) ? asm_frame : asm_frame + 16'd1;
		else
			stim_frame = first_frame;
		sender_gap_pct     = steady ? 0 : $urandom_range(0, 40);
		receiver_stall_pct = steady ? 0 : $urandom_range(0, 40);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (pause_midway && n == PHASE_ITEMS / 2)
				drain_results();
			send_packet(random_packet());
		end
	endtask

	// Phases with the register extremes, one with a fragment count that can never
	// complete, random settings, and a final phase with no idling on either side.
	task automatic test_register_sweep();
		run_random_phase(make_setting(RST_EXPECTED_TYPE, RST_EXPECTED_VERSION,
			RST_EXPECTED_FRAME_BYTES, RST_CHUNK_BYTES, RST_FRAGMENTS_PER_FRAME),
			16'($urandom_range(1, 60000)), 1'b0, 1'b0);
		run_random_phase(make_setting(8'd0, 8'd255, 23'd1, 16'd1, 4'd1),
			16'($urandom_range(1, 60000)), 1'b0, 1'b0);
		run_random_phase(make_setting(8'd255, 8'd0, 23'd4194304, 16'd65521, 4'd8),
			16'd65000, 1'b0, 1'b1);
		run_random_phase(make_setting(8'($urandom), 8'($urandom), 23'd100000, 16'd20000,
			4'd12), 16'($urandom_range(1, 60000)), 1'b0, 1'b0);
		for (int i = 0; i < 3; i++)
			run_random_phase(random_setting(), 16'($urandom_range(1, 60000)), 1'b0, 1'b0);
		run_random_phase(random_setting(), 16'($urandom_range(1, 60000)), 1'b1, 1'b0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_checks();
		test_unused_register_indexes();
		test_midframe_config_change();
		test_register_sweep();
		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_results.size() == 0)
			$display("** video_fragment_reassembly_tracker: PASSED **");
		else
			$display("** video_fragment_reassembly_tracker: FAILED **");
		$finish;
	end

endmodule
